[rtl/spp_pkg.sv]
// Shared types and constants for the string-to-unsigned parser.
package spp_pkg;

    // Width of the saturating character count.
    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 64;
    localparam int BASE_BITS  = 5;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SPACE  = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0]           ch;
        logic                 first;
        logic [BASE_BITS-1:0] radix;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] consumed;
        logic                  bad_radix;
    } out_word_t;

    typedef struct packed {
        phase_t                phase;
        logic [BASE_BITS-1:0]  base;
        logic                  minus;
        logic [VALUE_BITS-1:0] acc;
        logic [COUNT_BITS-1:0] count;
    } state_t;

    typedef struct packed {
        state_t    state;
        logic      res_valid;
        out_word_t res;
    } step_t;

endpackage

[rtl/string_to_unsigned_parser_top.sv]
// Top level of the string-to-unsigned parser: input register, parse step, result register.
// The parser takes one character word per cycle and reads one unsigned number per string:
// a word with first set starts a string and carries the base (0 for auto-detect, 2 to 16),
// leading whitespace, a sign, a leading zero and a 0x or 0b prefix are taken, and digits
// accumulate modulo 2^64. The first character that is not a digit of the base ends the
// string and produces one result word holding the value, the number of characters taken
// (saturating) and a bad_radix flag; a base of 1 or above 16 ends the string on its first
// character with a zero result. Characters after the end, and characters before any first,
// are dropped silently. A character is held in the input register and the parse step then
// updates the state and loads the result register. One character is taken every cycle
// unless the block stalls; the only limit is the multiply-add by the base on the 64-bit
// accumulator. The block stalls only when a new result is due while the previous one has
// not yet been taken.
module string_to_unsigned_parser_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spp_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output spp_pkg::out_word_t out_word
);

    logic               in_vld_reg;
    spp_pkg::in_word_t  in_word_reg;
    spp_pkg::state_t    state_reg;
    logic               out_vld_reg;
    spp_pkg::out_word_t out_word_reg;
    spp_pkg::step_t     step;
    logic               stage_go;

    spp_step u_step
    (
        .state (state_reg),
        .word  (in_word_reg),
        .step  (step)
    );

    // The held character moves on unless it ends a string while the last result waits.
    assign stage_go  = in_vld_reg && (!step.res_valid || !out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || stage_go;
    assign out_valid = out_vld_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            state_reg.phase <= spp_pkg::PH_IDLE;
            state_reg.base  <= '0;
            state_reg.minus <= 1'b0;
            state_reg.acc   <= '0;
            state_reg.count <= '0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (stage_go)
            begin
                state_reg <= step.state;
            end
            if (stage_go && step.res_valid)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
        if (stage_go && step.res_valid)
        begin
            out_word_reg <= step.res;
        end
    end

    // A bad base always reports an empty result.
    a_bad_radix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_word_reg.bad_radix |->
            out_word_reg.value == '0 && out_word_reg.consumed == '0)
        else $error("bad_radix result carries nonzero data");

    // Producing a result always closes the string.
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && step.res_valid |=> state_reg.phase == spp_pkg::PH_DONE && out_vld_reg)
        else $error("result loaded without closing the string");

    // A held character that cannot move on stays put.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !stage_go |=> in_vld_reg && $stable(in_word_reg))
        else $error("held character lost while stalled");

    // The character count never wraps within a string.
    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && !in_word_reg.first && state_reg.count == '1 |=> state_reg.count == '1)
        else $error("character count wrapped");

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> $stable(out_word_reg))
        else $error("pending result overwritten");

endmodule

[rtl/spp_step.sv]
// Combinational parse step: one character against the current parse state.
module spp_step
(
    input  spp_pkg::state_t   state,
    input  spp_pkg::in_word_t word,
    output spp_pkg::step_t    step
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_AUTO = 5'd0;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_BIN  = 5'd2;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_OCT  = 5'd8;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_DEC  = 5'd10;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_HEX  = 5'd16;
    localparam logic [spp_pkg::BASE_BITS-1:0] NO_DIGIT  = 5'd16;

    // Digit value of a character, or sixteen when it is no digit at all.
    function automatic logic [spp_pkg::BASE_BITS-1:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                t = c - CH_ZERO;
            end
            else if (c >= CH_LA && c <= CH_LF)
            begin
                t = c - CH_LA + 8'd10;
            end
            else if (c >= CH_UA && c <= CH_UF)
            begin
                t = c - CH_UA + 8'd10;
            end
            else
            begin
                t = 8'(NO_DIGIT);
            end
            digit_of = t[spp_pkg::BASE_BITS-1:0];
        end
    endfunction

    spp_pkg::state_t               st;
    logic                          handled;
    logic                          take;
    logic [spp_pkg::BASE_BITS-1:0] dig;
    logic                          is_space;
    logic                          bad;

    assign dig      = digit_of(word.ch);
    assign is_space = (word.ch == CH_SPACE) || (word.ch >= CH_TAB && word.ch <= CH_CR);
    assign bad      = (word.radix == 5'd1) || (word.radix > BASE_HEX);

    always_comb
    begin
        st             = state;
        handled        = 1'b0;
        take           = 1'b0;
        step.res_valid = 1'b0;
        step.res       = '0;

        if (word.first)
        begin
            st.minus = 1'b0;
            st.acc   = '0;
            st.count = '0;
            if (bad)
            begin
                st.base             = BASE_AUTO;
                st.phase            = spp_pkg::PH_DONE;
                step.res_valid      = 1'b1;
                step.res.bad_radix  = 1'b1;
            end
            else
            begin
                st.base  = word.radix;
                st.phase = spp_pkg::PH_SPACE;
            end
        end

        if (step.res_valid || st.phase == spp_pkg::PH_IDLE || st.phase == spp_pkg::PH_DONE)
        begin
            handled = 1'b1;
        end

        if (!handled && st.phase == spp_pkg::PH_SPACE)
        begin
            if (is_space)
            begin
                take    = 1'b1;
                handled = 1'b1;
            end
            else if (word.ch == CH_PLUS || word.ch == CH_MINUS)
            begin
                st.minus = (word.ch == CH_MINUS);
                take     = 1'b1;
                handled  = 1'b1;
                st.phase = spp_pkg::PH_ZERO;
            end
            else
            begin
                st.phase = spp_pkg::PH_ZERO;
            end
        end

        if (!handled && st.phase == spp_pkg::PH_ZERO)
        begin
            if (word.ch == CH_ZERO)
            begin
                take     = 1'b1;
                handled  = 1'b1;
                st.phase = spp_pkg::PH_PREFIX;
            end
            else
            begin
                if (st.base == BASE_AUTO)
                begin
                    st.base = BASE_DEC;
                end
                st.phase = spp_pkg::PH_DIGITS;
            end
        end

        if (!handled && st.phase == spp_pkg::PH_PREFIX)
        begin
            if ((st.base == BASE_AUTO || st.base == BASE_HEX) &&
                (word.ch == CH_LX || word.ch == CH_UX))
            begin
                st.base  = BASE_HEX;
                take     = 1'b1;
                handled  = 1'b1;
            end
            else if ((st.base == BASE_AUTO || st.base == BASE_BIN) &&
                     (word.ch == CH_LB || word.ch == CH_UB))
            begin
                st.base  = BASE_BIN;
                take     = 1'b1;
                handled  = 1'b1;
            end
            else if (st.base == BASE_AUTO)
            begin
                st.base = BASE_OCT;
            end
            st.phase = spp_pkg::PH_DIGITS;
        end

        if (!handled)
        begin
            if (dig < st.base)
            begin
                st.acc = st.acc * spp_pkg::VALUE_BITS'(st.base)
                         + spp_pkg::VALUE_BITS'(dig);
                take   = 1'b1;
            end
            else
            begin
                step.res_valid          = 1'b1;
                step.res.value          = st.minus ? ('0 - st.acc) : st.acc;
                step.res.consumed       = st.count;
                step.res.bad_radix      = 1'b0;
                st.phase                = spp_pkg::PH_DONE;
            end
        end

        // The count sticks at all ones once it gets there.
        if (take && st.count != '1)
        begin
            st.count = st.count + 1'b1;
        end

        step.state = st;
    end

endmodule

[bench/tb_string_to_unsigned_parser_top.sv]
// Self-checking testbench for the string-to-unsigned parser, with a cycle-free parse predictor.
`timescale 1ns / 1ps

module tb_string_to_unsigned_parser_top;

    // Character codes that the parser treats specially.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_A       = "a";
    localparam logic [7:0] CH_F       = "f";
    localparam logic [7:0] CH_A_UP    = "A";
    localparam logic [7:0] CH_F_UP    = "F";
    localparam logic [7:0] CH_X       = "x";
    localparam logic [7:0] CH_X_UP    = "X";
    localparam logic [7:0] CH_B       = "b";
    localparam logic [7:0] CH_B_UP    = "B";

    // Bases with a meaning of their own.
    localparam logic [spp_pkg::BASE_BITS-1:0] RADIX_AUTO = 5'd0;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_BIN   = 5'd2;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_OCT   = 5'd8;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_DEC   = 5'd10;
    localparam logic [spp_pkg::BASE_BITS-1:0] BASE_HEX   = 5'd16;

    // Cycles without any accepted word, on either side, before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Random input words per idling phase that the parser actually looks at.
    localparam int PHASE_WORDS = 160;

    localparam spp_pkg::out_word_t NO_RESULT = '0;

    // One row of the directed table: the input word, and where the result is obvious from
    // the definition, the result that the row must end with.
    typedef struct packed {
        logic [7:0]                    ch;
        logic                          first;
        logic [spp_pkg::BASE_BITS-1:0] radix;
        logic                          typed;
        spp_pkg::out_word_t            want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    spp_pkg::in_word_t  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    spp_pkg::out_word_t out_word;

    // Shadow copy of the parser state, advanced once per accepted input word.
    spp_pkg::phase_t                char_phase = spp_pkg::PH_IDLE;
    logic [spp_pkg::BASE_BITS-1:0]  char_base  = '0;
    logic                           char_minus = 1'b0;
    logic [spp_pkg::VALUE_BITS-1:0] char_acc   = '0;
    logic [spp_pkg::COUNT_BITS-1:0] char_count = '0;

    // Parse results still owed by the block, oldest first.
    spp_pkg::out_word_t parsed_q[$];

    int n_err        = 0;
    int n_live       = 0;
    int quiet_cycles = 0;
    int send_idle    = 0;   // percent of cycles the sender holds back a word
    int recv_stall   = 0;   // percent of cycles the receiver refuses a result

    // The directed part. The first rows check the idle and bad-base corners, then come
    // short strings for whitespace and sign, the 0x prefix, base-0 octal detection (the
    // digit right after the leading zero is taken, not skipped, and an 8 ends the string),
    // the 0B prefix, an abandoned string, a prefix with no digits after it, and a sign
    // with no digits after it.
    dir_row_t dir_rows [0:25] = '{
        '{"7",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{8'h00,    1'b1, 5'd1,       1'b1, '{64'd0, 16'd0, 1'b1}},
        '{8'hFF,    1'b1, 5'd31,      1'b1, '{64'd0, 16'd0, 1'b1}},
        '{"9",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{CH_TAB,   1'b1, BASE_DEC,   1'b0, NO_RESULT},
        '{"+",      1'b0, 5'd31,      1'b0, NO_RESULT},
        '{"7",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{CH_SPACE, 1'b0, RADIX_AUTO, 1'b1, '{64'd7, 16'd3, 1'b0}},
        '{"-",      1'b1, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"0",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"x",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"F",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"G",      1'b0, RADIX_AUTO, 1'b1, '{64'hFFFF_FFFF_FFFF_FFF1, 16'd4, 1'b0}},
        '{"0",      1'b1, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"1",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"8",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"0",      1'b1, BASE_BIN,   1'b0, NO_RESULT},
        '{"B",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"1",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"2",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"9",      1'b1, BASE_DEC,   1'b0, NO_RESULT},
        '{"0",      1'b1, BASE_HEX,   1'b0, NO_RESULT},
        '{"X",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"z",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT},
        '{"-",      1'b1, BASE_DEC,   1'b0, NO_RESULT},
        '{"!",      1'b0, RADIX_AUTO, 1'b0, NO_RESULT}
    };

    string_to_unsigned_parser_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // The receiver refuses results at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic report_mismatch(input string msg);
        n_err++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // The character count saturates at all ones.
    function automatic void take_char();
        if (char_count != '1)
            char_count++;
    endfunction

    // Advances the shadow parser by one character word. Returns 1 when the word ends a
    // string, with the parse result in res.
    function automatic bit parse_char(input spp_pkg::in_word_t w,
                                      output spp_pkg::out_word_t res);
        logic [spp_pkg::BASE_BITS-1:0] dig;
        res = '0;
        if (w.first)
        begin
            char_minus = 1'b0;
            char_acc   = '0;
            char_count = '0;
            // A base of 1 or above 16 ends the string on the spot with nothing taken.
            if (w.radix == 5'd1 || w.radix > BASE_HEX)
            begin
                char_base     = RADIX_AUTO;
                char_phase    = spp_pkg::PH_DONE;
                res.bad_radix = 1'b1;
                return 1'b1;
            end
            char_base  = w.radix;
            char_phase = spp_pkg::PH_SPACE;
        end
        if (char_phase == spp_pkg::PH_IDLE || char_phase == spp_pkg::PH_DONE)
            return 1'b0;

        // The phases fall through: a character that does not fit one phase is offered to
        // the next one in the same step.
        if (char_phase == spp_pkg::PH_SPACE)
        begin
            if (w.ch == CH_SPACE || (w.ch >= CH_TAB && w.ch <= CH_CR))
            begin
                take_char();
                return 1'b0;
            end
            if (w.ch == CH_PLUS || w.ch == CH_MINUS)
            begin
                char_minus = (w.ch == CH_MINUS);
                take_char();
                char_phase = spp_pkg::PH_ZERO;
                return 1'b0;
            end
            char_phase = spp_pkg::PH_ZERO;
        end
        if (char_phase == spp_pkg::PH_ZERO)
        begin
            if (w.ch == CH_ZERO)
            begin
                take_char();
                char_phase = spp_pkg::PH_PREFIX;
                return 1'b0;
            end
            if (char_base == RADIX_AUTO)
                char_base = BASE_DEC;
            char_phase = spp_pkg::PH_DIGITS;
        end
        if (char_phase == spp_pkg::PH_PREFIX)
        begin
            if ((char_base == RADIX_AUTO || char_base == BASE_HEX)
                && (w.ch == CH_X || w.ch == CH_X_UP))
            begin
                char_base = BASE_HEX;
                take_char();
                char_phase = spp_pkg::PH_DIGITS;
                return 1'b0;
            end
            if ((char_base == RADIX_AUTO || char_base == BASE_BIN)
                && (w.ch == CH_B || w.ch == CH_B_UP))
            begin
                char_base = BASE_BIN;
                take_char();
                char_phase = spp_pkg::PH_DIGITS;
                return 1'b0;
            end
            // Auto base after a leading zero means octal; the character is not skipped.
            if (char_base == RADIX_AUTO)
                char_base = BASE_OCT;
            char_phase = spp_pkg::PH_DIGITS;
        end

        // Digit phase: 16 stands for "not a digit at all".
        if (w.ch >= CH_ZERO && w.ch <= CH_NINE)
            dig = 5'(w.ch - CH_ZERO);
        else if (w.ch >= CH_A && w.ch <= CH_F)
            dig = 5'(w.ch - CH_A + 8'd10);
        else if (w.ch >= CH_A_UP && w.ch <= CH_F_UP)
            dig = 5'(w.ch - CH_A_UP + 8'd10);
        else
            dig = BASE_HEX;
        if (dig < char_base)
        begin
            char_acc = char_acc * spp_pkg::VALUE_BITS'(char_base)
                       + spp_pkg::VALUE_BITS'(dig);
            take_char();
            return 1'b0;
        end
        res.value    = char_minus ? -char_acc : char_acc;
        res.consumed = char_count;
        char_phase   = spp_pkg::PH_DONE;
        return 1'b1;
    endfunction

    // Offers one word, waits for it to be taken and records what it must produce. The
    // handshake is read at the falling edge, where both valid and ready are settled, and
    // the word counts as taken at the rising edge that follows. After that the sender may
    // sit idle for a while, at the rate of the current phase.
    task automatic send_word(input spp_pkg::in_word_t w, input bit typed,
                             input spp_pkg::out_word_t want);
        spp_pkg::out_word_t res;
        bit                 ends;
        bit                 live;
        in_word  <= w;
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (!in_ready);
        live = w.first || (char_phase != spp_pkg::PH_IDLE && char_phase != spp_pkg::PH_DONE);
        ends = parse_char(w, res);
        if (typed)
            parsed_q.push_back(want);
        else if (ends)
            parsed_q.push_back(res);
        if (live)
            n_live++;
        @(posedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Sends one well-formed string with random content: whitespace, sign, leading zero,
    // prefix, digits of the base in force, a terminator and a little trailing junk. Now
    // and then the string is cut short, so the next first word abandons it.
    task automatic send_random_string();
        spp_pkg::in_word_t             w;
        logic [spp_pkg::BASE_BITS-1:0] r;
        logic [7:0]                    pre;
        logic [7:0]                    text[$];
        int unsigned                   eff;
        int unsigned                   v;
        int                            n_dig;
        bit                            zero;
        bit                            all_max;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: r = RADIX_AUTO;
            6, 7:             r = BASE_DEC;
            8, 9:             r = BASE_HEX;
            10:               r = BASE_BIN;
            11:               r = BASE_OCT;
            12, 13, 14, 15:   r = 5'($urandom_range(2, 16));
            16:               r = ($urandom_range(1) != 0) ? 5'd1 : 5'($urandom_range(17, 31));
            default:          r = 5'($urandom_range(31));
        endcase
        repeat ($urandom_range(3))
        begin
            v = $urandom_range(8, 13);
            text.push_back((v == 8) ? CH_SPACE : 8'(v));
        end
        case ($urandom_range(2))
            1:       text.push_back(CH_PLUS);
            2:       text.push_back(CH_MINUS);
            default: ;
        endcase
        zero = ($urandom_range(1) != 0);
        pre  = '0;
        if (zero)
        begin
            text.push_back(CH_ZERO);
            if ($urandom_range(1) != 0)
            begin
                case ($urandom_range(3))
                    0:       pre = CH_X;
                    1:       pre = CH_X_UP;
                    2:       pre = CH_B;
                    default: pre = CH_B_UP;
                endcase
                text.push_back(pre);
            end
        end
        // The base the digits are drawn from; the predictor decides what really counts.
        if (r == RADIX_AUTO)
            eff = (pre == CH_X || pre == CH_X_UP) ? 16 :
                  (pre == CH_B || pre == CH_B_UP) ? 2 : zero ? 8 : 10;
        else if (r >= BASE_BIN && r <= BASE_HEX)
            eff = 32'(r);
        else
            eff = 10;
        // Mostly short numbers; some long enough to wrap the 64-bit value.
        n_dig   = ($urandom_range(9) == 0) ? $urandom_range(14, 26) : $urandom_range(6);
        all_max = ($urandom_range(15) == 0);
        repeat (n_dig)
        begin
            v = all_max ? eff - 1 : $urandom_range(eff - 1);
            if (v < 10)
                text.push_back(CH_ZERO + 8'(v));
            else
                text.push_back((($urandom_range(1) != 0) ? CH_A : CH_A_UP) + 8'(v - 10));
        end
        if ($urandom_range(19) != 0)
        begin
            text.push_back(($urandom_range(1) != 0) ? 8'($urandom_range(255)) : CH_SPACE);
            repeat ($urandom_range(2))
                text.push_back(8'($urandom_range(255)));
        end
        if (text.size() == 0)
            text.push_back(8'($urandom_range(255)));
        foreach (text[i])
        begin
            w.ch    = text[i];
            w.first = (i == 0);
            // The base field is only read on the first word; elsewhere it is noise.
            w.radix = (i == 0) ? r : 5'($urandom_range(31));
            send_word(w, 1'b0, NO_RESULT);
        end
    endtask

    // One idling phase of random traffic: mostly strings, some loose noise words.
    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        spp_pkg::in_word_t w;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        n_live     = 0;
        while (n_live < PHASE_WORDS)
        begin
            if ($urandom_range(9) == 0)
            begin
                w.ch    = 8'($urandom_range(255));
                w.first = ($urandom_range(4) == 0);
                w.radix = 5'($urandom_range(31));
                send_word(w, 1'b0, NO_RESULT);
            end
            else
            begin
                send_random_string();
            end
        end
        drain_results();
    endtask

    // Result checker and watchdog. A result is compared at the falling edge before the
    // rising edge that takes it; valid and ready cannot change in between.
    always @(negedge clk)
    begin
        spp_pkg::out_word_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TIMEOUT: no word moved for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else if (out_valid && out_ready)
            begin
                if (parsed_q.size() == 0)
                begin
                    report_mismatch($sformatf("result word with nothing owed: %h", out_word));
                end
                else
                begin
                    want = parsed_q.pop_front();
                    if (out_word.value !== want.value)
                        report_mismatch($sformatf("value %h, owed %h",
                                                  out_word.value, want.value));
                    if (out_word.consumed !== want.consumed)
                        report_mismatch($sformatf("consumed %0d, owed %0d",
                                                  out_word.consumed, want.consumed));
                    if (out_word.bad_radix !== want.bad_radix)
                        report_mismatch($sformatf("bad_radix %b, owed %b",
                                                  out_word.bad_radix, want.bad_radix));
                end
            end
        end
    end

    initial
    begin
        spp_pkg::in_word_t w;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at full rate on both sides.
        foreach (dir_rows[i])
        begin
            w.ch    = dir_rows[i].ch;
            w.first = dir_rows[i].first;
            w.radix = dir_rows[i].radix;
            send_word(w, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_results();

        // Random traffic: no idling, a mostly idle sender, a mostly stalling receiver,
        // then light idling on both sides. Each phase ends with the sender held off until
        // every owed result has arrived.
        run_random_phase(0, 0);
        run_random_phase(87, 0);
        run_random_phase(0, 87);
        run_random_phase(10, 10);

        // Let a stray extra result, if any, show up before the verdict.
        recv_stall = 0;
        repeat (10) @(posedge clk);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
